// ===== sv/eaq_pkg.sv =====
// Package for the Euler angle to quaternion unit: CORDIC constants and types.
package eaq_pkg;

	localparam int CW = 34;          // CORDIC x/y width, Q2.30 plus margin
	localparam int ZW = 34;          // residual angle width
	localparam int PW = 64;          // product width
	localparam int OW = 16;          // result width
	localparam int MAX_ITER = 32;
	localparam int ADDR_W = 1;
	localparam logic [ADDR_W-1:0] REG_DIRECTION = 1'b0;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;

	typedef logic signed [CW-1:0] cord_t;
	typedef logic signed [ZW-1:0] ang_t;

	typedef struct packed {
		cord_t x;
		cord_t y;
		ang_t  z;
	} rot_t;

	// Three rotators travel side by side through the cell chain.
	typedef struct packed {
		rot_t h;
		rot_t p;
		rot_t b;
	} trio_t;

	function automatic ang_t atan_entry(input int i);
		ang_t r;
		case (i)
			0: r = 34'sd1073741824;
			1: r = 34'sd633866811;
			2: r = 34'sd334917815;
			3: r = 34'sd170009512;
			4: r = 34'sd85334662;
			5: r = 34'sd42708931;
			6: r = 34'sd21359677;
			7: r = 34'sd10680490;
			8: r = 34'sd5340326;
			9: r = 34'sd2670174;
			10: r = 34'sd1335088;
			11: r = 34'sd667544;
			12: r = 34'sd333772;
			13: r = 34'sd166886;
			14: r = 34'sd83443;
			15: r = 34'sd41722;
			16: r = 34'sd20861;
			17: r = 34'sd10430;
			18: r = 34'sd5215;
			19: r = 34'sd2608;
			20: r = 34'sd1304;
			21: r = 34'sd652;
			22: r = 34'sd326;
			23: r = 34'sd163;
			24: r = 34'sd81;
			25: r = 34'sd41;
			26: r = 34'sd20;
			27: r = 34'sd10;
			28: r = 34'sd5;
			29: r = 34'sd3;
			30: r = 34'sd1;
			31: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [OW-1:0] sat_q15(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] r;
		r = (v + (64'sd1 <<< 44)) >>> 45;
		if (r > 64'sd32767) return 16'sh7fff;
		if (r < -64'sd32768) return 16'sh8000;
		return r[OW-1:0];
	endfunction

endpackage

// ===== sv/eaq_cell.sv =====
// One CORDIC micro-rotation cell for three angles, registered.
module eaq_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  eaq_pkg::trio_t d,
	output logic          vld_out,
	output eaq_pkg::trio_t q
);
	import eaq_pkg::*;

	localparam ang_t ATAN = atan_entry(STEP);

	function automatic rot_t rotate(input rot_t r);
		rot_t o;
		cord_t dx;
		cord_t dy;
		dx = r.y >>> STEP;
		dy = r.x >>> STEP;
		if (!r.z[ZW-1]) begin
			o.x = r.x - dx;
			o.y = r.y + dy;
			o.z = r.z - ATAN;
		end else begin
			o.x = r.x + dx;
			o.y = r.y - dy;
			o.z = r.z + ATAN;
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.h <= rotate(d.h);
			q.p <= rotate(d.p);
			q.b <= rotate(d.b);
		end
	end

endmodule

// ===== sv/eaq_combine.sv =====
// Triple products, conjugate and Q1.15 rounding over three pipeline stages.
module eaq_combine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  logic                        direction,
	input  eaq_pkg::trio_t              d,
	output logic                        vld_out,
	output logic signed [eaq_pkg::OW-1:0] w,
	output logic signed [eaq_pkg::OW-1:0] x,
	output logic signed [eaq_pkg::OW-1:0] y,
	output logic signed [eaq_pkg::OW-1:0] z
);
	import eaq_pkg::*;

	typedef logic signed [PW-1:0] wide_t;

	function automatic wide_t pr30(input cord_t a, input cord_t b);
		wide_t p;
		p = wide_t'(a) * wide_t'(b);
		return (p + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// stage 1: pairwise products, back in Q2.30 so stage 2 stays a CW x CW multiply
	cord_t hp_cc_s1, hp_cs_s1, hp_sc_s1, hp_ss_s1;
	cord_t cb_s1, sb_s1;
	logic  vld_s1, dir_s1;
	// stage 2: triple products
	wide_t t_s2 [8];
	logic  vld_s2, dir_s2;
	logic  vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hp_cc_s1 <= cord_t'(pr30(d.h.x, d.p.x));
			hp_cs_s1 <= cord_t'(pr30(d.h.x, d.p.y));
			hp_sc_s1 <= cord_t'(pr30(d.h.y, d.p.x));
			hp_ss_s1 <= cord_t'(pr30(d.h.y, d.p.y));
			cb_s1    <= d.b.x;
			sb_s1    <= d.b.y;
			dir_s1   <= direction;
			t_s2[0]  <= wide_t'(hp_cc_s1) * wide_t'(cb_s1);
			t_s2[1]  <= wide_t'(hp_ss_s1) * wide_t'(sb_s1);
			t_s2[2]  <= wide_t'(hp_cs_s1) * wide_t'(cb_s1);
			t_s2[3]  <= wide_t'(hp_sc_s1) * wide_t'(sb_s1);
			t_s2[4]  <= wide_t'(hp_sc_s1) * wide_t'(cb_s1);
			t_s2[5]  <= wide_t'(hp_cs_s1) * wide_t'(sb_s1);
			t_s2[6]  <= wide_t'(hp_cc_s1) * wide_t'(sb_s1);
			t_s2[7]  <= wide_t'(hp_ss_s1) * wide_t'(cb_s1);
			dir_s2   <= dir_s1;
			w <= sat_q15(t_s2[0] + t_s2[1]);
			x <= sat_q15(dir_s2 ? -(t_s2[2] + t_s2[3]) : (t_s2[2] + t_s2[3]));
			y <= sat_q15(dir_s2 ? -(t_s2[4] - t_s2[5]) : (t_s2[4] - t_s2[5]));
			z <= sat_q15(dir_s2 ? -(t_s2[6] - t_s2[7]) : (t_s2[6] - t_s2[7]));
		end
	end

	assign vld_out = vld_s3;

endmodule

// ===== sv/euler_angles_to_quaternion_unit.sv =====
// Top level: Euler angles to quaternion, CORDIC cell chain plus product stages.
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall  | heading, pitch_angle, bank_angle
//  out     | out | out_valid/out_stall| quat_w, quat_x, quat_y, quat_z
//  cfg     | in  | APB                | direction at address 0
// One item per cycle while the output is not stalled; the stages are one cell per
// micro-rotation, three product/rounding stages, one output register.
// Reset clears the valid bits and direction. A stalled output freezes the whole
// chain; the input is stalled only while the output holds an item not taken.
module euler_angles_to_quaternion_unit #(
	parameter int ANGLE_BITS      = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [ANGLE_BITS-1:0] heading,
	input  logic signed [ANGLE_BITS-1:0] pitch_angle,
	input  logic signed [ANGLE_BITS-1:0] bank_angle,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [eaq_pkg::OW-1:0] quat_w,
	output logic signed [eaq_pkg::OW-1:0] quat_x,
	output logic signed [eaq_pkg::OW-1:0] quat_y,
	output logic signed [eaq_pkg::OW-1:0] quat_z,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [eaq_pkg::ADDR_W+1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import eaq_pkg::*;

	localparam int NCELL = (TRIG_ITERATIONS > MAX_ITER) ? MAX_ITER : TRIG_ITERATIONS;

	logic direction_q;
	logic en;
	logic vld_c [NCELL+1];
	trio_t dat_c [NCELL+1];
	logic vld_m;
	logic signed [OW-1:0] w_m, x_m, y_m, z_m;

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W+1:2] == REG_DIRECTION) ? {31'd0, direction_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[ADDR_W+1:2] == REG_DIRECTION) begin
			direction_q <= pwdata[0];
		end
	end

	// Chain advances unless a finished item waits at a stalled output.
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	function automatic rot_t seed(input logic signed [ANGLE_BITS-1:0] a);
		rot_t r;
		r.x = CORDIC_GAIN;
		r.y = '0;
		r.z = ZW'(a) <<< (32 - ANGLE_BITS);
		return r;
	endfunction

	assign vld_c[0]   = in_valid;
	assign dat_c[0].h = seed(heading);
	assign dat_c[0].p = seed(pitch_angle);
	assign dat_c[0].b = seed(bank_angle);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		eaq_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_c[i]), .d(dat_c[i]),
			.vld_out(vld_c[i+1]), .q(dat_c[i+1])
		);
	end

	eaq_combine u_combine (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_c[NCELL]), .direction(direction_q), .d(dat_c[NCELL]),
		.vld_out(vld_m), .w(w_m), .x(x_m), .y(y_m), .z(z_m)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_w <= w_m;
			quat_x <= x_m;
			quat_y <= y_m;
			quat_z <= z_m;
		end
	end

endmodule
